### sv/fch_pkg.sv
// shared constants, types and the lane fold function for the chunk hasher
// no dependencies
package fch_pkg;

	localparam int unsigned MAX_CHUNK = 4096;
	localparam int unsigned ADDR_W = $clog2(MAX_CHUNK);
	localparam int unsigned LEN_W = $clog2(MAX_CHUNK + 1);
	localparam int unsigned LANE_W = 64;

	localparam logic [LANE_W-1:0] FNV_OFFSET = 64'hcbf29ce484222325;

	localparam logic [2:0] CMD_BYTE    = 3'd0;
	localparam logic [2:0] CMD_CLOSE   = 3'd1;
	localparam logic [2:0] CMD_MIX     = 3'd2;
	localparam logic [2:0] CMD_FINISH  = 3'd3;
	localparam logic [2:0] CMD_RESTART = 3'd4;

	localparam logic REG_SEED_HIGH = 1'b0;
	localparam logic REG_SEED_LOW  = 1'b1;

	typedef enum logic [1:0] {
		LANE_HOLD,
		LANE_SEED,
		LANE_WORD,
		LANE_STORE
	} lane_op_t;

	typedef struct packed {
		logic              mem_we;
		logic [ADDR_W-1:0] mem_waddr;
		logic [ADDR_W-1:0] rd_addr_hi;
		logic [ADDR_W-1:0] rd_addr_lo;
		logic              word_load;
		logic              word_from_len;
		logic [LEN_W-1:0]  len;
		lane_op_t          lane_op;
		logic [2:0]        byte_sel;
		logic              out_load;
		logic              overflow;
	} dp_cmd_t;

	// (lane ^ b) * 0x100000001b3 as shifts and adds
	function automatic logic [LANE_W-1:0] fold_byte(input logic [LANE_W-1:0] lane,
			input logic [7:0] b);
		logic [LANE_W-1:0] x;
		x = lane ^ {{(LANE_W-8){1'b0}}, b};
		return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
	endfunction

endpackage

### sv/dual_lane_fnv1a_chunk_hasher.sv
// top level of the dual-lane fnv-1a chunk hasher: sequencer plus datapath
// depends on fch_pkg, fch_ctrl, fch_datapath
// chunk byte, finish, restart: accepted in idle; mix word: accept, then one fold per byte, most significant first
// close chunk: length folded as a word, then the stored bytes, one fold per lane per cycle, store read ahead
// finish result is in the output register from the cycle after the transaction
// async reset: seeds and lanes to the fnv offset basis, empty chunk, overflow clear
module dual_lane_fnv1a_chunk_hasher import fch_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_valid,
	output logic        cmd_stall,
	input  logic [2:0]  command,
	input  logic [7:0]  byte_value,
	input  logic [63:0] word_value,
	output logic        hash_valid,
	input  logic        hash_stall,
	output logic [63:0] hash_high,
	output logic [63:0] hash_low,
	output logic        chunk_overflow,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [63:0] cfg_data
);

	dp_cmd_t dp_cmd;

	assign cfg_ready = 1'b1;

	fch_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (cmd_valid),
		.cmd_stall  (cmd_stall),
		.command    (command),
		.hash_valid (hash_valid),
		.hash_stall (hash_stall),
		.dp_cmd     (dp_cmd)
	);

	fch_datapath u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (dp_cmd),
		.byte_value     (byte_value),
		.word_value     (word_value),
		.cfg_we         (cfg_valid && cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.hash_high      (hash_high),
		.hash_low       (hash_low),
		.chunk_overflow (chunk_overflow)
	);

endmodule

### sv/fch_datapath.sv
// lanes, seed registers, chunk store, word register and result register
// depends on fch_pkg
module fch_datapath import fch_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  dp_cmd_t           cmd,
	input  logic [7:0]        byte_value,
	input  logic [63:0]       word_value,
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [63:0]       cfg_data,
	output logic [63:0]       hash_high,
	output logic [63:0]       hash_low,
	output logic              chunk_overflow
);

	logic [LANE_W-1:0] seed_high_q, seed_low_q;
	logic [LANE_W-1:0] high_q, low_q;
	logic [LANE_W-1:0] word_q;
	logic [7:0]        store_mem [MAX_CHUNK];
	logic [7:0]        rd_hi_q, rd_lo_q;
	logic [7:0]        word_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_high_q <= FNV_OFFSET;
			seed_low_q  <= FNV_OFFSET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SEED_HIGH: seed_high_q <= cfg_data;
				REG_SEED_LOW:  seed_low_q  <= cfg_data;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mem_we) begin
			store_mem[cmd.mem_waddr] <= byte_value;
		end
		rd_hi_q <= store_mem[cmd.rd_addr_hi];
		rd_lo_q <= store_mem[cmd.rd_addr_lo];
	end

	always_ff @(posedge clk) begin
		if (cmd.word_load) begin
			word_q <= cmd.word_from_len ? {{(LANE_W-LEN_W){1'b0}}, cmd.len} : word_value;
		end
	end

	// big-endian byte pick
	assign word_byte = word_q[(LANE_W-1) - 8*cmd.byte_sel -: 8];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			high_q <= FNV_OFFSET;
			low_q  <= FNV_OFFSET;
		end else begin
			unique case (cmd.lane_op)
				LANE_HOLD: ;
				LANE_SEED: begin
					high_q <= seed_high_q;
					low_q  <= seed_low_q;
				end
				LANE_WORD: begin
					high_q <= fold_byte(high_q, word_byte);
					low_q  <= fold_byte(low_q, word_byte);
				end
				LANE_STORE: begin
					high_q <= fold_byte(high_q, rd_hi_q);
					low_q  <= fold_byte(low_q, rd_lo_q);
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			hash_high      <= high_q;
			hash_low       <= (high_q == '0 && low_q == '0) ? 64'd1 : low_q;
			chunk_overflow <= cmd.overflow;
		end
	end

endmodule

### sv/fch_ctrl.sv
// command sequencer: handshakes, chunk length, overflow flag, fold sequencing
// depends on fch_pkg
module fch_ctrl import fch_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cmd_valid,
	output logic       cmd_stall,
	input  logic [2:0] command,
	output logic       hash_valid,
	input  logic       hash_stall,
	output dp_cmd_t    dp_cmd
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_WORD,
		S_BYTES
	} state_t;

	state_t           state_q;
	logic [LEN_W-1:0] len_q;
	logic [LEN_W-1:0] idx_q;
	logic [2:0]       k_q;
	logic             close_q;
	logic             ovf_q;
	logic             accept;
	logic             room;
	logic [LEN_W-1:0] hi_next, lo_next, lo_first;

	assign cmd_stall = (state_q != S_IDLE) || (command == CMD_FINISH && hash_valid && hash_stall);
	assign accept = cmd_valid && !cmd_stall;
	assign room = len_q < LEN_W'(MAX_CHUNK);

	assign hi_next  = idx_q + LEN_W'(1);
	assign lo_next  = len_q - LEN_W'(2) - idx_q;
	assign lo_first = len_q - LEN_W'(1);

	always_comb begin
		dp_cmd               = '0;
		dp_cmd.lane_op       = LANE_HOLD;
		dp_cmd.len           = len_q;
		dp_cmd.overflow      = ovf_q;
		dp_cmd.byte_sel      = k_q;
		dp_cmd.mem_waddr     = len_q[ADDR_W-1:0];
		dp_cmd.rd_addr_hi    = '0;
		dp_cmd.rd_addr_lo    = lo_first[ADDR_W-1:0];
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					unique case (command)
						CMD_BYTE:    dp_cmd.mem_we = room;
						CMD_CLOSE: begin
							dp_cmd.word_load     = 1'b1;
							dp_cmd.word_from_len = 1'b1;
						end
						CMD_MIX:     dp_cmd.word_load = 1'b1;
						CMD_FINISH:  dp_cmd.out_load = 1'b1;
						CMD_RESTART: dp_cmd.lane_op = LANE_SEED;
						default: ;
					endcase
				end
			end
			S_WORD: dp_cmd.lane_op = LANE_WORD;
			S_BYTES: begin
				dp_cmd.lane_op    = LANE_STORE;
				dp_cmd.rd_addr_hi = hi_next[ADDR_W-1:0];
				dp_cmd.rd_addr_lo = lo_next[ADDR_W-1:0];
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			len_q      <= '0;
			idx_q      <= '0;
			k_q        <= '0;
			close_q    <= 1'b0;
			ovf_q      <= 1'b0;
			hash_valid <= 1'b0;
		end else begin
			if (hash_valid && !hash_stall && !(accept && command == CMD_FINISH)) begin
				hash_valid <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						unique case (command)
							CMD_BYTE: begin
								if (room) begin
									len_q <= len_q + LEN_W'(1);
								end else begin
									ovf_q <= 1'b1;
								end
							end
							CMD_CLOSE: begin
								state_q <= S_WORD;
								k_q     <= '0;
								close_q <= 1'b1;
							end
							CMD_MIX: begin
								state_q <= S_WORD;
								k_q     <= '0;
								close_q <= 1'b0;
							end
							CMD_FINISH: hash_valid <= 1'b1;
							CMD_RESTART: begin
								len_q <= '0;
								ovf_q <= 1'b0;
							end
							default: ;
						endcase
					end
				end
				S_WORD: begin
					k_q <= k_q + 3'd1;
					if (k_q == 3'd7) begin
						if (close_q && len_q != '0) begin
							state_q <= S_BYTES;
							idx_q   <= '0;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				S_BYTES: begin
					idx_q <= hi_next;
					if (hi_next == len_q) begin
						state_q <= S_IDLE;
						len_q   <= '0;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= LEN_W'(MAX_CHUNK))
		else $error("chunk length beyond buffer");

	a_write_room: assert property (@(posedge clk) disable iff (!arst_n)
		dp_cmd.mem_we |-> (room && state_q == S_IDLE))
		else $error("store write without room");

	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_BYTES |-> idx_q < len_q)
		else $error("byte index past chunk length");

	a_finish_result: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && command == CMD_FINISH) |=> hash_valid)
		else $error("finish gave no result");

	a_close_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_BYTES && hi_next == len_q) |=> (state_q == S_IDLE && len_q == '0))
		else $error("chunk not cleared after close");

endmodule

### tb/tb_top.sv
// self-checking testbench for dual_lane_fnv1a_chunk_hasher: directed cases, a full-buffer
// chunk and random chunk traffic with and without random idling, checked against an in-bench predictor
// depends on fch_pkg and the hasher top level
module tb_top;
	import fch_pkg::*;

	localparam logic [63:0] LANE_PRIME = 64'h0000_0100_0000_01b3;
	localparam logic [2:0] CMD_SPARE_FIRST = 3'd5;
	localparam logic [2:0] CMD_SPARE_LAST = 3'd7;
	localparam int unsigned SETTLE_CYCLES = 4200;
	localparam int unsigned IDLE_NONE = 0;
	localparam int unsigned IDLE_RANDOM = 1;
	localparam int unsigned IDLE_SPARSE = 2;

	typedef struct {
		logic [2:0]  cmd;
		logic [7:0]  bval;
		logic [63:0] wval;
		int unsigned gap;
		bit          drain;
	} cmd_item_t;

	typedef struct packed {
		logic [63:0] high;
		logic [63:0] low;
		logic        ovf;
	} hash_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cmd_valid = 1'b0;
	logic        cmd_stall;
	logic [2:0]  command = '0;
	logic [7:0]  byte_value = '0;
	logic [63:0] word_value = '0;
	logic        hash_valid;
	logic        hash_stall = 1'b0;
	logic [63:0] hash_high;
	logic [63:0] hash_low;
	logic        chunk_overflow;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic        cfg_index = 1'b0;
	logic [63:0] cfg_data = '0;

	cmd_item_t    cmd_backlog[$];
	hash_result_t pending_hashes[$];
	cmd_item_t    cur_item = '{cmd: '0, bval: '0, wval: '0, gap: 0, drain: 1'b0};
	int unsigned  tx_wait = 0;
	int unsigned  rx_wait = 0;
	int unsigned  tx_mode = IDLE_RANDOM;
	int unsigned  rx_mode = IDLE_RANDOM;
	int unsigned  fail_count = 0;

	logic [63:0] pred_seed_high = FNV_OFFSET;
	logic [63:0] pred_seed_low = FNV_OFFSET;
	logic [63:0] pred_high = FNV_OFFSET;
	logic [63:0] pred_low = FNV_OFFSET;
	logic [7:0]  pred_store [MAX_CHUNK];
	int unsigned pred_len = 0;
	logic        pred_ovf = 1'b0;

	dual_lane_fnv1a_chunk_hasher u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd_valid      (cmd_valid),
		.cmd_stall      (cmd_stall),
		.command        (command),
		.byte_value     (byte_value),
		.word_value     (word_value),
		.hash_valid     (hash_valid),
		.hash_stall     (hash_stall),
		.hash_high      (hash_high),
		.hash_low       (hash_low),
		.chunk_overflow (chunk_overflow),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic logic [63:0] lane_mix(input logic [63:0] lane, input logic [7:0] b);
		return (lane ^ {56'd0, b}) * LANE_PRIME;
	endfunction

	function automatic int unsigned draw_wait(input int unsigned mode);
		if (mode == IDLE_NONE)
			return 0;
		if (mode == IDLE_SPARSE)
			return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 14) : 0;
		return $urandom_range(0, 14);
	endfunction

	function automatic logic [63:0] pick_word();
		int unsigned sel;
		sel = $urandom_range(0, 7);
		if (sel == 0)
			return '0;
		if (sel == 1)
			return '1;
		return {$urandom, $urandom};
	endfunction

	task automatic mix_word_into_lanes(input logic [63:0] w);
		int k;
		for (k = 7; k >= 0; k--) begin
			pred_high = lane_mix(pred_high, w[8*k +: 8]);
			pred_low = lane_mix(pred_low, w[8*k +: 8]);
		end
	endtask

	task automatic hasher_step(input cmd_item_t it);
		hash_result_t r;
		int unsigned k;
		case (it.cmd)
			CMD_BYTE: begin
				if (pred_len < MAX_CHUNK) begin
					pred_store[pred_len] = it.bval;
					pred_len++;
				end else begin
					pred_ovf = 1'b1;
				end
			end
			CMD_CLOSE: begin
				mix_word_into_lanes(64'(pred_len));
				for (k = 0; k < pred_len; k++) begin
					pred_high = lane_mix(pred_high, pred_store[k]);
					pred_low = lane_mix(pred_low, pred_store[pred_len - 1 - k]);
				end
				pred_len = 0;
			end
			CMD_MIX: mix_word_into_lanes(it.wval);
			CMD_FINISH: begin
				r.high = pred_high;
				r.low = (pred_high == '0 && pred_low == '0) ? 64'd1 : pred_low;
				r.ovf = pred_ovf;
				pending_hashes.push_back(r);
			end
			CMD_RESTART: begin
				pred_high = pred_seed_high;
				pred_low = pred_seed_low;
				pred_len = 0;
				pred_ovf = 1'b0;
			end
			default: ;
		endcase
	endtask

	// command driver
	always @(posedge clk) begin
		logic busy;
		if (!arst_n) begin
			cmd_valid <= 1'b0;
		end else begin
			busy = cmd_valid;
			if (cmd_valid && !cmd_stall) begin
				hasher_step(cur_item);
				busy = 1'b0;
				tx_wait = (cmd_backlog.size() != 0) ? cmd_backlog[0].gap : 0;
			end
			if (!busy) begin
				if (tx_wait != 0) begin
					tx_wait--;
				end else if (cmd_backlog.size() != 0 &&
						!(cmd_backlog[0].drain && pending_hashes.size() != 0)) begin
					cur_item = cmd_backlog.pop_front();
					busy = 1'b1;
				end
			end
			cmd_valid <= busy;
			command <= cur_item.cmd;
			byte_value <= cur_item.bval;
			word_value <= cur_item.wval;
		end
	end

	// hash monitor
	always @(posedge clk) begin
		hash_result_t want;
		int unsigned w;
		if (!arst_n) begin
			hash_stall <= 1'b0;
		end else begin
			w = rx_wait;
			if (hash_valid && !hash_stall) begin
				if (pending_hashes.size() == 0) begin
					$error("hash transaction with no expected result");
					fail_count++;
				end else begin
					want = pending_hashes.pop_front();
					if (hash_high !== want.high) begin
						$error("hash_high: expected %h, got %h", want.high, hash_high);
						fail_count++;
					end
					if (hash_low !== want.low) begin
						$error("hash_low: expected %h, got %h", want.low, hash_low);
						fail_count++;
					end
					if (chunk_overflow !== want.ovf) begin
						$error("chunk_overflow: expected %b, got %b", want.ovf, chunk_overflow);
						fail_count++;
					end
				end
				w = draw_wait(rx_mode);
			end else if (w != 0) begin
				w--;
			end
			rx_wait = w;
			hash_stall <= (w != 0);
		end
	end

	task automatic push_item(input logic [2:0] cmd, input logic [7:0] bval,
			input logic [63:0] wval, input bit drain);
		cmd_item_t it;
		it.cmd = cmd;
		it.bval = bval;
		it.wval = wval;
		it.gap = draw_wait(tx_mode);
		it.drain = drain;
		cmd_backlog.push_back(it);
	endtask

	task automatic write_seed(input logic idx, input logic [63:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do
			@(posedge clk);
		while (!(cfg_valid && cfg_ready));
		if (idx == REG_SEED_HIGH)
			pred_seed_high = val;
		else
			pred_seed_low = val;
		cfg_valid <= 1'b0;
	endtask

	task automatic start_phase(input int unsigned txm, input int unsigned rxm);
		@(negedge clk);
		tx_mode = txm;
		rx_mode = rxm;
	endtask

	task automatic settle_block();
		while (cmd_backlog.size() != 0 || cmd_valid || pending_hashes.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic gen_traffic(input int unsigned n_items);
		int unsigned made;
		int unsigned len;
		int unsigned j;
		int unsigned pick;
		made = 0;
		push_item(CMD_RESTART, 8'($urandom), pick_word(), 1'b0);
		while (made < n_items) begin
			len = ($urandom_range(0, 15) == 0) ? $urandom_range(25, 300) : $urandom_range(0, 24);
			for (j = 0; j < len; j++)
				push_item(CMD_BYTE, 8'($urandom), pick_word(), 1'b0);
			made += len;
			pick = $urandom_range(0, 19);
			if (pick == 0)
				push_item(CMD_RESTART, 8'($urandom), pick_word(), 1'b0);
			else if (pick == 1)
				push_item(CMD_FINISH, 8'($urandom), pick_word(), 1'b0);
			else if (pick == 2)
				push_item(CMD_MIX, 8'($urandom), pick_word(), 1'b0);
			else
				push_item(CMD_CLOSE, 8'($urandom), pick_word(), 1'b0);
			made++;
			if ($urandom_range(0, 2) == 0) begin
				push_item(CMD_MIX, 8'($urandom), pick_word(), 1'b0);
				made++;
			end
			if ($urandom_range(0, 2) != 0) begin
				push_item(CMD_FINISH, 8'($urandom), pick_word(), $urandom_range(0, 29) == 0);
				made++;
			end
			if ($urandom_range(0, 24) == 0) begin
				push_item(CMD_RESTART, 8'($urandom), pick_word(), 1'b0);
				made++;
			end
			if ($urandom_range(0, 19) == 0)
				push_item(3'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST)), 8'($urandom),
					pick_word(), 1'b0);
		end
	endtask

	initial begin
		int unsigned j;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// reset seeds, open and empty chunks, repeated finish, spare commands
		start_phase(IDLE_RANDOM, IDLE_RANDOM);
		push_item(CMD_FINISH, 8'h00, 64'd0, 1'b0);
		push_item(CMD_BYTE, 8'h00, 64'd0, 1'b0);
		push_item(CMD_BYTE, 8'hff, 64'd0, 1'b0);
		push_item(CMD_MIX, 8'h00, '1, 1'b0);
		push_item(CMD_CLOSE, 8'h00, 64'd0, 1'b0);
		push_item(CMD_CLOSE, 8'h00, 64'd0, 1'b0);
		push_item(CMD_FINISH, 8'h00, 64'd0, 1'b0);
		push_item(CMD_FINISH, 8'h00, 64'd0, 1'b0);
		push_item(CMD_MIX, 8'hff, 64'd0, 1'b0);
		push_item(CMD_SPARE_FIRST, 8'hff, '1, 1'b0);
		push_item(3'd6, 8'h5a, 64'h0123_4567_89ab_cdef, 1'b0);
		push_item(CMD_SPARE_LAST, 8'hff, '1, 1'b0);
		push_item(CMD_FINISH, 8'h00, 64'd0, 1'b0);
		push_item(CMD_BYTE, 8'h3c, 64'd0, 1'b0);
		push_item(CMD_RESTART, 8'h00, 64'd0, 1'b0);
		push_item(CMD_CLOSE, 8'h00, 64'd0, 1'b0);
		push_item(CMD_FINISH, 8'h00, 64'd0, 1'b1);
		settle_block();

		// zero seeds: lanes unchanged until restart, then the all-zero finish
		write_seed(REG_SEED_HIGH, 64'd0);
		write_seed(REG_SEED_LOW, 64'd0);
		start_phase(IDLE_SPARSE, IDLE_RANDOM);
		push_item(CMD_FINISH, 8'h00, 64'd0, 1'b0);
		push_item(CMD_RESTART, 8'h00, 64'd0, 1'b0);
		push_item(CMD_FINISH, 8'h00, 64'd0, 1'b0);
		push_item(CMD_MIX, 8'h00, 64'd0, 1'b0);
		push_item(CMD_FINISH, 8'h00, 64'd0, 1'b0);
		settle_block();

		write_seed(REG_SEED_HIGH, '1);
		start_phase(IDLE_RANDOM, IDLE_SPARSE);
		push_item(CMD_RESTART, 8'h00, 64'd0, 1'b0);
		push_item(CMD_FINISH, 8'h00, 64'd0, 1'b0);
		settle_block();

		// full buffer, then dropped bytes and the sticky flag
		start_phase(IDLE_NONE, IDLE_RANDOM);
		push_item(CMD_RESTART, 8'h00, 64'd0, 1'b0);
		for (j = 0; j < MAX_CHUNK; j++)
			push_item(CMD_BYTE, 8'($urandom), 64'd0, 1'b0);
		push_item(CMD_FINISH, 8'h00, 64'd0, 1'b0);
		for (j = 0; j < 5; j++)
			push_item(CMD_BYTE, 8'($urandom), 64'd0, 1'b0);
		push_item(CMD_FINISH, 8'h00, 64'd0, 1'b0);
		push_item(CMD_CLOSE, 8'h00, 64'd0, 1'b0);
		push_item(CMD_FINISH, 8'h00, 64'd0, 1'b0);
		push_item(CMD_BYTE, 8'h81, 64'd0, 1'b0);
		push_item(CMD_FINISH, 8'h00, 64'd0, 1'b0);
		push_item(CMD_RESTART, 8'h00, 64'd0, 1'b0);
		push_item(CMD_FINISH, 8'h00, 64'd0, 1'b0);
		settle_block();

		write_seed(REG_SEED_HIGH, {$urandom, $urandom});
		write_seed(REG_SEED_LOW, {$urandom, $urandom});
		start_phase(IDLE_RANDOM, IDLE_RANDOM);
		gen_traffic(450);
		settle_block();

		write_seed(REG_SEED_HIGH, '1);
		write_seed(REG_SEED_LOW, '1);
		start_phase(IDLE_NONE, IDLE_NONE);
		gen_traffic(400);
		settle_block();

		write_seed(REG_SEED_HIGH, FNV_OFFSET);
		write_seed(REG_SEED_LOW, {$urandom, $urandom});
		start_phase(IDLE_SPARSE, IDLE_RANDOM);
		gen_traffic(450);
		settle_block();

		write_seed(REG_SEED_HIGH, {$urandom, $urandom});
		write_seed(REG_SEED_LOW, 64'd0);
		start_phase(IDLE_RANDOM, IDLE_NONE);
		gen_traffic(400);
		settle_block();

		if (pending_hashes.size() != 0) begin
			$error("%0d expected hash results never arrived", pending_hashes.size());
			fail_count++;
		end
		if (fail_count == 0)
			$display("** dual_lane_fnv1a_chunk_hasher: PASSED **");
		else
			$display("** dual_lane_fnv1a_chunk_hasher: FAILED **");
		$finish;
	end

	initial begin
		#8000000;
		$display("** dual_lane_fnv1a_chunk_hasher: FAILED **");
		$finish;
	end

endmodule
